/* hdl/sapr_pkg.sv */
// ----------------------------------------------------------------------------
// sapr_pkg
// Shared types and constants of the smoothed allpass phase rotator: register
// indexes, multiplier operand selects and the controller/datapath interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sapr_pkg;

   localparam int NUM_CHANNELS_DEF = 2;
   localparam int SAMPLE_BITS_DEF  = 24;

   localparam int CHAN_BITS      = 2;
   localparam int COEFF_BITS     = 16;
   localparam int AMOUNT_BITS    = 16;
   localparam int RATE_BITS      = 16;
   localparam int ACTIVE_BITS    = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int MUL_A_BITS     = 17;

   localparam logic [RATE_BITS-1:0]   RATE_RESET   = 16'hFFFF;
   localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 2'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_TARGET_COEFF_0  = 3'd0,
      REG_TARGET_AMOUNT_0 = 3'd1,
      REG_TARGET_COEFF_1  = 3'd2,
      REG_TARGET_AMOUNT_1 = 3'd3,
      REG_SMOOTHING_RATE  = 3'd4,
      REG_ACTIVE_CHANNELS = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_COEFF   = 2'd0,
      MUL_AMOUNT  = 2'd1,
      MUL_ALLPASS = 2'd2,
      MUL_MIX     = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        upd_coeff;
      logic        upd_amount;
      logic        upd_allpass;
      logic        load_out;
      logic        out_pass;
   } dp_cmd_type;

   typedef struct packed {
      logic req_active;
   } dp_sts_type;

endpackage

`default_nettype wire

/* hdl/sapr_ctrl.sv */
// ----------------------------------------------------------------------------
// sapr_ctrl
// Sequencer of the rotator: accepts a word, steps the shared multiplier
// through glide, allpass and mix, and holds the result word until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sapr_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   input  sapr_pkg::dp_sts_type   sts,
   output sapr_pkg::dp_cmd_type   cmd
);
   import sapr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COEFF,
      ST_AMOUNT,
      ST_ALLPASS,
      ST_YSUM,
      ST_MIX,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      pass_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd             = '0;
      cmd.mul_sel     = MUL_COEFF;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
         end
         ST_COEFF: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_COEFF;
         end
         ST_AMOUNT: begin
            cmd.upd_coeff = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_AMOUNT;
         end
         ST_ALLPASS: begin
            cmd.upd_amount = 1'b1;
            cmd.mul_en     = 1'b1;
            cmd.mul_sel    = MUL_ALLPASS;
         end
         ST_YSUM: begin
            cmd.upd_allpass = 1'b1;
         end
         ST_MIX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_MIX;
         end
         ST_FINISH: begin
            cmd.load_out = out_free;
            cmd.out_pass = pass_ff;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  pass_ff  <= !sts.req_active;
                  state_ff <= sts.req_active ? ST_COEFF : ST_FINISH;
               end
            end
            ST_COEFF:   state_ff <= ST_AMOUNT;
            ST_AMOUNT:  state_ff <= ST_ALLPASS;
            ST_ALLPASS: state_ff <= ST_YSUM;
            ST_YSUM:    state_ff <= ST_MIX;
            ST_MIX:     state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

/* hdl/sapr_dpath.sv */
// ----------------------------------------------------------------------------
// sapr_dpath
// Datapath of the rotator: control registers, per-channel state, one shared
// multiplier with a product register, rounding, saturation and output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sapr_dpath #(
   parameter int NUM_CHANNELS = sapr_pkg::NUM_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = sapr_pkg::SAMPLE_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  sapr_pkg::dp_cmd_type                 cmd,
   output sapr_pkg::dp_sts_type                 sts,
   input  wire                                  csr_valid,
   input  wire [sapr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire [sapr_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  wire [sapr_pkg::CHAN_BITS-1:0]        req_channel_index,
   input  wire signed [SAMPLE_BITS-1:0]         req_sample_in,
   output logic signed [SAMPLE_BITS-1:0]        rsp_sample_out
);
   import sapr_pkg::*;

   localparam int CH_IDX_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int DIFF_BITS   = SAMPLE_BITS + 1;
   localparam int PROD_BITS   = MUL_A_BITS + DIFF_BITS;

   localparam logic signed [PROD_BITS-1:0] SAT_HI =
      {{(PROD_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [PROD_BITS-1:0] SAT_LO = ~SAT_HI;
   localparam logic signed [PROD_BITS-1:0] HALF16 = PROD_BITS'(1) << 15;
   localparam logic signed [PROD_BITS-1:0] HALF15 = PROD_BITS'(1) << 14;

   // control registers
   logic signed [COEFF_BITS-1:0]  target_coeff_ff  [2];
   logic        [AMOUNT_BITS-1:0] target_amount_ff [2];
   logic        [RATE_BITS-1:0]   rate_ff;
   logic        [ACTIVE_BITS-1:0] active_ff;

   // per-channel state
   logic signed [COEFF_BITS-1:0]  cur_coeff_ff  [NUM_CHANNELS];
   logic        [AMOUNT_BITS-1:0] cur_amount_ff [NUM_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] prev_in_ff    [NUM_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] prev_ap_ff    [NUM_CHANNELS];

   // working registers
   logic        [CHAN_BITS-1:0]   ch_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [SAMPLE_BITS-1:0] out_ff;

   logic        [CH_IDX_BITS-1:0] ch_idx;
   logic signed [COEFF_BITS-1:0]  c_cur;
   logic        [AMOUNT_BITS-1:0] a_cur;
   logic signed [SAMPLE_BITS-1:0] x1;
   logic signed [SAMPLE_BITS-1:0] y1;
   logic signed [COEFF_BITS-1:0]  tc;
   logic        [AMOUNT_BITS-1:0] ta;

   logic signed [MUL_A_BITS-1:0]  coeff_diff;
   logic signed [MUL_A_BITS-1:0]  amount_diff;
   logic signed [DIFF_BITS-1:0]   ap_diff;
   logic signed [DIFF_BITS-1:0]   mix_diff;
   logic signed [MUL_A_BITS-1:0]  op_a;
   logic signed [DIFF_BITS-1:0]   op_b;
   logic signed [PROD_BITS-1:0]   prod_in;

   logic signed [PROD_BITS-1:0]   rnd16;
   logic signed [PROD_BITS-1:0]   rnd15;
   logic signed [PROD_BITS-1:0]   coeff_sum;
   logic signed [PROD_BITS-1:0]   amount_sum;
   logic signed [PROD_BITS-1:0]   ap_sum;
   logic signed [PROD_BITS-1:0]   mix_sum;
   logic signed [SAMPLE_BITS-1:0] ap_sat;
   logic signed [SAMPLE_BITS-1:0] mix_sat;

   assign ch_idx = ch_ff[CH_IDX_BITS-1:0];
   assign c_cur  = cur_coeff_ff[ch_idx];
   assign a_cur  = cur_amount_ff[ch_idx];
   assign x1     = prev_in_ff[ch_idx];
   assign y1     = prev_ap_ff[ch_idx];
   assign tc     = target_coeff_ff[ch_ff[0]];
   assign ta     = target_amount_ff[ch_ff[0]];

   assign sts.req_active = (req_channel_index < active_ff) &&
                           ({1'b0, req_channel_index} < 3'(NUM_CHANNELS));

   assign coeff_diff  = {tc[COEFF_BITS-1], tc} - {c_cur[COEFF_BITS-1], c_cur};
   assign amount_diff = {1'b0, ta} - {1'b0, a_cur};
   assign ap_diff     = {x_ff[SAMPLE_BITS-1], x_ff} - {y1[SAMPLE_BITS-1], y1};
   assign mix_diff    = {y1[SAMPLE_BITS-1], y1} - {x_ff[SAMPLE_BITS-1], x_ff};

   always_comb begin
      case (cmd.mul_sel)
         MUL_COEFF: begin
            op_a = {1'b0, rate_ff};
            op_b = DIFF_BITS'(coeff_diff);
         end
         MUL_AMOUNT: begin
            op_a = {1'b0, rate_ff};
            op_b = DIFF_BITS'(amount_diff);
         end
         MUL_ALLPASS: begin
            op_a = {c_cur[COEFF_BITS-1], c_cur};
            op_b = ap_diff;
         end
         MUL_MIX: begin
            op_a = {1'b0, a_cur};
            op_b = mix_diff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = op_a * op_b;

   assign rnd16      = (prod_ff + HALF16) >>> 16;
   assign rnd15      = (prod_ff + HALF15) >>> 15;
   assign coeff_sum  = PROD_BITS'(c_cur) + rnd16;
   assign amount_sum = {{(PROD_BITS-AMOUNT_BITS){1'b0}}, a_cur} + rnd16;
   assign ap_sum     = rnd15 + PROD_BITS'(x1);
   assign mix_sum    = rnd16 + PROD_BITS'(x_ff);

   assign ap_sat  = (ap_sum > SAT_HI)  ? SAT_HI[SAMPLE_BITS-1:0] :
                    (ap_sum < SAT_LO)  ? SAT_LO[SAMPLE_BITS-1:0] :
                                         ap_sum[SAMPLE_BITS-1:0];
   assign mix_sat = (mix_sum > SAT_HI) ? SAT_HI[SAMPLE_BITS-1:0] :
                    (mix_sum < SAT_LO) ? SAT_LO[SAMPLE_BITS-1:0] :
                                         mix_sum[SAMPLE_BITS-1:0];

   assign rsp_sample_out = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            target_coeff_ff[i]  <= '0;
            target_amount_ff[i] <= '0;
         end
         rate_ff   <= RATE_RESET;
         active_ff <= ACTIVE_RESET;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            cur_coeff_ff[i]  <= '0;
            cur_amount_ff[i] <= '0;
            prev_in_ff[i]    <= '0;
            prev_ap_ff[i]    <= '0;
         end
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_TARGET_COEFF_0:  target_coeff_ff[0]  <= csr_data;
               REG_TARGET_AMOUNT_0: target_amount_ff[0] <= csr_data;
               REG_TARGET_COEFF_1:  target_coeff_ff[1]  <= csr_data;
               REG_TARGET_AMOUNT_1: target_amount_ff[1] <= csr_data;
               REG_SMOOTHING_RATE:  rate_ff             <= csr_data;
               REG_ACTIVE_CHANNELS: active_ff           <= csr_data[ACTIVE_BITS-1:0];
               default: ;
            endcase
         end
         if (cmd.upd_coeff) begin
            cur_coeff_ff[ch_idx] <= coeff_sum[COEFF_BITS-1:0];
         end
         if (cmd.upd_amount) begin
            cur_amount_ff[ch_idx] <= amount_sum[AMOUNT_BITS-1:0];
         end
         if (cmd.upd_allpass) begin
            prev_ap_ff[ch_idx] <= ap_sat;
            prev_in_ff[ch_idx] <= x_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ch_ff <= req_channel_index;
         x_ff  <= req_sample_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.load_out) begin
         out_ff <= cmd.out_pass ? x_ff : mix_sat;
      end
   end

endmodule

`default_nettype wire

/* hdl/smoothed_allpass_phase_rotator_core.sv */
// ----------------------------------------------------------------------------
// smoothed_allpass_phase_rotator_core
// Per-channel first-order allpass with gliding coefficient and dry/wet mix.
//
//   channel  direction  handshake               word
//   req      in         req_valid / req_ready   req_channel_index, req_sample_in
//   rsp      out        rsp_valid / rsp_ready   rsp_sample_out
//   csr      in         csr_valid / csr_ready   csr_index, csr_data
//
// An active-channel word runs through six sequencer steps before the next
// ready, four of them passes through the single shared multiplier, with
// rounding, update and saturation between them.
// A pass-through word goes straight to the last step.
// The result word waits in an output register; the sequencer stalls in its
// last step while that register is still full and not being taken.
// Synchronous reset restores the control registers and channel state at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smoothed_allpass_phase_rotator_core #(
   parameter int NUM_CHANNELS = sapr_pkg::NUM_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = sapr_pkg::SAMPLE_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire [sapr_pkg::CHAN_BITS-1:0]        req_channel_index,
   input  wire signed [SAMPLE_BITS-1:0]         req_sample_in,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]        rsp_sample_out,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [sapr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire [sapr_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import sapr_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   assign csr_ready = 1'b1;

   sapr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sapr_dpath #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_valid         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_channel_index (req_channel_index),
      .req_sample_in     (req_sample_in),
      .rsp_sample_out    (rsp_sample_out)
   );

`ifndef SYNTHESIS
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || rsp_ready))
      else $error("output word overwritten before taken");

   a_idle_no_update: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(cmd.upd_coeff || cmd.upd_amount || cmd.upd_allpass))
      else $error("channel state updated while idle");

   a_pass_no_glide: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !sts.req_active) |=> (cmd.load_out || !cmd.mul_en))
      else $error("inactive channel entered the arithmetic sequence");

   a_single_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.upd_coeff, cmd.upd_amount, cmd.upd_allpass, cmd.load_out}))
      else $error("overlapping datapath updates");
`endif

endmodule

`default_nettype wire

/* tb/sapr_tb_pkg.sv */
// ----------------------------------------------------------------------------
// sapr_tb_pkg
// Scoreboard for the allpass phase rotator bench. It shadows the CSR
// registers and the per-channel glide and filter state. From each accepted
// input word it computes the expected output word and queues it. Output
// words are checked against the queue in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sapr_tb_pkg;
   import sapr_pkg::*;

   localparam int LANES = NUM_CHANNELS_DEF;
   localparam int SW    = SAMPLE_BITS_DEF;

   typedef logic signed [SW-1:0] sample_t;

   class rotator_scoreboard;
      logic signed [COEFF_BITS-1:0] coeff_goal [2];
      logic [AMOUNT_BITS-1:0]       amount_goal [2];
      logic [RATE_BITS-1:0]         glide_rate;
      logic [ACTIVE_BITS-1:0]       active_count;
      logic signed [COEFF_BITS-1:0] coeff_now [LANES];
      logic [AMOUNT_BITS-1:0]       amount_now [LANES];
      sample_t                      last_in [LANES];
      sample_t                      last_ap [LANES];
      sample_t                      expected_q [$];
      int                           mismatches;

      function new();
         for (int i = 0; i < 2; i++) begin
            coeff_goal[i]  = '0;
            amount_goal[i] = '0;
         end
         for (int i = 0; i < LANES; i++) begin
            coeff_now[i]  = '0;
            amount_now[i] = '0;
            last_in[i]    = '0;
            last_ap[i]    = '0;
         end
         glide_rate   = RATE_RESET;
         active_count = ACTIVE_RESET;
         mismatches   = 0;
      endfunction

      // add half an LSB, then floor
      function longint round_shift(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function longint clamp_sample(longint v);
         longint top;
         top = (longint'(1) <<< (SW - 1)) - 1;
         if (v > top) return top;
         if (v < -top - 1) return -top - 1;
         return v;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] idx,
                                   logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            REG_TARGET_COEFF_0:  coeff_goal[0]  = data;
            REG_TARGET_AMOUNT_0: amount_goal[0] = data;
            REG_TARGET_COEFF_1:  coeff_goal[1]  = data;
            REG_TARGET_AMOUNT_1: amount_goal[1] = data;
            REG_SMOOTHING_RATE:  glide_rate     = data;
            REG_ACTIVE_CHANNELS: active_count   = data[ACTIVE_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic [CHAN_BITS-1:0] lane, sample_t x);
         int unsigned lanes_on;
         longint      c, a, y, mixed;
         lanes_on = (active_count > LANES) ? LANES : active_count;
         if (lane >= lanes_on) begin
            expected_q.push_back(x);
            return;
         end
         c = coeff_now[lane];
         c += round_shift((longint'(coeff_goal[lane]) - c) * longint'(glide_rate), 16);
         coeff_now[lane] = c[COEFF_BITS-1:0];
         a = amount_now[lane];
         a += round_shift((longint'(amount_goal[lane]) - a) * longint'(glide_rate), 16);
         amount_now[lane] = a[AMOUNT_BITS-1:0];
         y = clamp_sample(round_shift(c * (longint'(x) - longint'(last_ap[lane])), 15)
                          + longint'(last_in[lane]));
         last_in[lane] = x;
         last_ap[lane] = y[SW-1:0];
         mixed = clamp_sample(longint'(x) + round_shift(a * (y - longint'(x)), 16));
         expected_q.push_back(mixed[SW-1:0]);
      endfunction

      function void check_output(sample_t got);
         sample_t want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected output word, expected none, actual %0d", $time, got);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time, want, got);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for smoothed_allpass_phase_rotator_core. A directed run
// covers sample extremes, saturation, inactive and pass-through channels,
// glide stall and an unmapped CSR index. Randomized phases follow, each with
// its own register setting and idle pattern. One phase holds the output off
// long enough to back up the input. Every output word is checked against
// the scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import sapr_pkg::*;
   import sapr_tb_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_WORDS = 85;
   localparam int NUM_PHASES  = 8;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNMAPPED = 3'd7;
   localparam sample_t SAMPLE_MAX = sample_t'((longint'(1) <<< (SW - 1)) - 1);
   localparam sample_t SAMPLE_MIN = ~SAMPLE_MAX;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [CHAN_BITS-1:0]      req_channel_index;
   sample_t                   req_sample_in;
   logic                      rsp_valid;
   logic                      rsp_ready;
   sample_t                   rsp_sample_out;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   int                sender_idle_pct;
   int                receiver_stall_pct;
   int                cycle_count;
   int                hold_left;
   bit                hold_request;
   rotator_scoreboard sb;

   smoothed_allpass_phase_rotator_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_channel_index (req_channel_index),
      .req_sample_in     (req_sample_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_out    (rsp_sample_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // output side: random stalls, plus one long hold on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_output(rsp_sample_out);
         if (req_valid && req_ready) sb.note_sample(req_channel_index, req_sample_in);
         if (csr_valid && csr_ready) sb.write_register(csr_index, csr_data);
      end
   end

   task automatic send_sample(input logic [CHAN_BITS-1:0] lane, input sample_t x);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid         <= 1'b1;
      req_channel_index <= lane;
      req_sample_in     <= x;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait until every expected word is out
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input int coeff0, input int amount0, input int coeff1,
                                 input int amount1, input int rate, input int lanes_on);
      write_csr(REG_TARGET_COEFF_0, 16'(coeff0));
      write_csr(REG_TARGET_AMOUNT_0, 16'(amount0));
      write_csr(REG_TARGET_COEFF_1, 16'(coeff1));
      write_csr(REG_TARGET_AMOUNT_1, 16'(amount1));
      write_csr(REG_SMOOTHING_RATE, 16'(rate));
      write_csr(REG_ACTIVE_CHANNELS, 16'(lanes_on));
   endtask

   initial begin
      logic [CHAN_BITS-1:0] lane;
      sample_t              word;
      sb                 = new();
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_channel_index  = '0;
      req_sample_in      = '0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_data           = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_request       = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: zero amount, every channel comes out dry
      send_sample(0, SAMPLE_MAX);
      send_sample(1, SAMPLE_MIN);
      send_sample(2, '0);
      send_sample(3, -1);

      // extreme coefficients at full wet, drive into saturation
      settle();
      apply_settings(-32768, 65535, 32767, 65535, 65535, 2);
      write_csr(REG_UNMAPPED, 16'h1234);
      send_sample(0, SAMPLE_MAX);
      send_sample(0, SAMPLE_MIN);
      send_sample(0, SAMPLE_MAX);
      send_sample(1, SAMPLE_MIN);
      send_sample(1, SAMPLE_MAX);
      send_sample(1, SAMPLE_MIN);
      send_sample(0, '0);
      send_sample(1, -1);
      send_sample(2, SAMPLE_MAX);
      send_sample(3, SAMPLE_MIN);

      // one channel active, targets one step away at the slowest rate
      settle();
      apply_settings(-32767, 65534, 32767, 65535, 1, 1);
      send_sample(0, 24'sd12345);
      send_sample(0, -24'sd12345);
      send_sample(1, SAMPLE_MAX);
      send_sample(3, 24'sd5);

      // no active channel: everything passes
      settle();
      apply_settings(0, 0, 0, 0, 65535, 0);
      send_sample(0, SAMPLE_MAX);
      send_sample(1, SAMPLE_MIN);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         case (p)
            0: apply_settings(32767, 65535, -32768, 65535, 65535, 2);
            1: apply_settings($urandom, $urandom, $urandom, $urandom, $urandom, 2);
            2: apply_settings($urandom, $urandom, $urandom, $urandom, 0, 1);
            3: apply_settings($urandom, $urandom, $urandom, $urandom,
                              $urandom_range(64, 1), 2);
            4: apply_settings($urandom, $urandom, $urandom, $urandom, $urandom, 3);
            5: apply_settings($urandom, $urandom, $urandom, $urandom, $urandom, 0);
            6: apply_settings($urandom, $urandom, $urandom, $urandom, 65535, 2);
            default: apply_settings($urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom_range(3));
         endcase
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 78; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 78; end
            default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
         endcase
         if (p == 6) hold_request = 1'b1;
         repeat (PHASE_WORDS) begin
            lane = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1));
            case ($urandom_range(9))
               0: word = SAMPLE_MAX;
               1: word = SAMPLE_MIN;
               2: word = sample_t'(int'($urandom_range(511)) - 256);
               default: word = sample_t'($urandom);
            endcase
            send_sample(lane, word);
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/sapr_pkg.sv
hdl/sapr_ctrl.sv
hdl/sapr_dpath.sv
hdl/smoothed_allpass_phase_rotator_core.sv
tb/sapr_tb_pkg.sv
tb/tb_top.sv
